// File: rtl/mwdc_pkg.sv
// ----------------------------------------------------------------------------
// mwdc_pkg
// Shared constants, the letter-to-Morse table and the back-end state type
// for the distinct Morse word counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mwdc_pkg;

    localparam int MAX_WORDS_DEF   = 128;
    localparam int MAX_SYMBOLS_DEF = 48;
    localparam int LETTER_W        = 5;
    localparam int COUNT_OUT_W     = 8;
    localparam int CODE_BITS_W     = 4;
    localparam int CODE_LEN_W      = 3;
    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

    typedef struct packed {
        logic [CODE_BITS_W-1:0] bits;
        logic [CODE_LEN_W-1:0]  len;
    } t_code;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RES
    } t_back_state;

    // Symbol k of a code sits in bit k, dot = 0 and dash = 1.
    function automatic t_code mwdc_code(input logic [LETTER_W-1:0] letter);
        t_code c;
        case (letter)
            5'd0:    c = '{bits: 4'd2,  len: 3'd2};
            5'd1:    c = '{bits: 4'd1,  len: 3'd4};
            5'd2:    c = '{bits: 4'd5,  len: 3'd4};
            5'd3:    c = '{bits: 4'd1,  len: 3'd3};
            5'd4:    c = '{bits: 4'd0,  len: 3'd1};
            5'd5:    c = '{bits: 4'd4,  len: 3'd4};
            5'd6:    c = '{bits: 4'd3,  len: 3'd3};
            5'd7:    c = '{bits: 4'd0,  len: 3'd4};
            5'd8:    c = '{bits: 4'd0,  len: 3'd2};
            5'd9:    c = '{bits: 4'd14, len: 3'd4};
            5'd10:   c = '{bits: 4'd5,  len: 3'd3};
            5'd11:   c = '{bits: 4'd2,  len: 3'd4};
            5'd12:   c = '{bits: 4'd3,  len: 3'd2};
            5'd13:   c = '{bits: 4'd1,  len: 3'd2};
            5'd14:   c = '{bits: 4'd7,  len: 3'd3};
            5'd15:   c = '{bits: 4'd6,  len: 3'd4};
            5'd16:   c = '{bits: 4'd11, len: 3'd4};
            5'd17:   c = '{bits: 4'd2,  len: 3'd3};
            5'd18:   c = '{bits: 4'd0,  len: 3'd3};
            5'd19:   c = '{bits: 4'd1,  len: 3'd1};
            5'd20:   c = '{bits: 4'd4,  len: 3'd3};
            5'd21:   c = '{bits: 4'd8,  len: 3'd4};
            5'd22:   c = '{bits: 4'd6,  len: 3'd3};
            5'd23:   c = '{bits: 4'd9,  len: 3'd4};
            5'd24:   c = '{bits: 4'd13, len: 3'd4};
            5'd25:   c = '{bits: 4'd3,  len: 3'd4};
            default: c = '{bits: 4'd0,  len: 3'd0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mwdc_front.sv
// ----------------------------------------------------------------------------
// mwdc_front
// Letter front end: appends each letter's Morse code to the word in progress
// and pushes a finished word, with its clear and overflow marks, to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwdc_front #(
    parameter int MAX_SYMBOLS = mwdc_pkg::MAX_SYMBOLS_DEF,
    parameter int SYM_W       = MAX_SYMBOLS,
    parameter int LEN_W       = $clog2(MAX_SYMBOLS + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_full,
    input  wire logic [mwdc_pkg::LETTER_W-1:0] i_letter,
    input  wire logic                          i_end_of_word,
    input  wire logic                          i_new_set,
    output logic                               o_push,
    output logic [SYM_W-1:0]                   o_job_bits,
    output logic [LEN_W-1:0]                   o_job_len,
    output logic                               o_job_ovf,
    output logic                               o_job_clr
);
    import mwdc_pkg::*;

    logic [SYM_W-1:0] r_pattern, n_pattern;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    logic             r_clr_pend, n_clr;
    logic [SYM_W-1:0] base_pattern;
    logic [LEN_W-1:0] base_len;
    logic             base_ovf;
    logic [LEN_W:0]   sum_len;
    logic             fits;
    logic             accept;
    t_code            code;

    always_comb begin
        accept       = i_start && !i_full;
        code         = mwdc_code(i_letter);
        base_pattern = i_new_set ? '0 : r_pattern;
        base_len     = i_new_set ? '0 : r_len;
        base_ovf     = i_new_set ? 1'b0 : r_ovf;
        n_clr        = i_new_set || r_clr_pend;
        sum_len      = {1'b0, base_len} + (LEN_W + 1)'(code.len);
        fits         = (sum_len <= (LEN_W + 1)'(MAX_SYMBOLS));
        // A code that does not fit is dropped and marks the word as too long.
        n_pattern    = fits ? (base_pattern | (SYM_W'(code.bits) << base_len))
                            : base_pattern;
        n_len        = fits ? sum_len[LEN_W-1:0] : base_len;
        n_ovf        = base_ovf || !fits;
        o_push       = accept && i_end_of_word;
        o_job_bits   = n_pattern;
        o_job_len    = n_len;
        o_job_ovf    = n_ovf;
        o_job_clr    = n_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_clr_pend <= 1'b0;
        end else if (accept) begin
            if (i_end_of_word) begin
                r_pattern  <= '0;
                r_len      <= '0;
                r_ovf      <= 1'b0;
                r_clr_pend <= 1'b0;
            end else begin
                r_pattern  <= n_pattern;
                r_len      <= n_len;
                r_ovf      <= n_ovf;
                r_clr_pend <= n_clr;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mwdc_fifo.sv
// ----------------------------------------------------------------------------
// mwdc_fifo
// Two-entry word queue between the letter front end and the table search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwdc_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/mwdc_back.sv
// ----------------------------------------------------------------------------
// mwdc_back
// Table search: compares a finished word with the stored patterns one entry
// per cycle, stores a new one and reports the running distinct count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwdc_back #(
    parameter int MAX_WORDS   = mwdc_pkg::MAX_WORDS_DEF,
    parameter int MAX_SYMBOLS = mwdc_pkg::MAX_SYMBOLS_DEF,
    parameter int SYM_W       = MAX_SYMBOLS,
    parameter int LEN_W       = $clog2(MAX_SYMBOLS + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [SYM_W-1:0]                 i_job_bits,
    input  wire logic [LEN_W-1:0]                 i_job_len,
    input  wire logic                             i_job_ovf,
    input  wire logic                             i_job_clr,
    output logic                                  o_pop,
    output logic                                  o_result_valid,
    output logic [mwdc_pkg::COUNT_OUT_W-1:0]      o_unique_count,
    output logic                                  o_was_new,
    output logic                                  o_overflow
);
    import mwdc_pkg::*;

    localparam int IDX_W   = $clog2(MAX_WORDS);
    localparam int CNT_W   = $clog2(MAX_WORDS + 1);
    localparam int ENTRY_W = SYM_W + LEN_W;

    logic [ENTRY_W-1:0] r_mem [MAX_WORDS];
    logic [ENTRY_W-1:0] r_rd_data;

    t_back_state              r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_addr, n_addr;
    logic                     r_rd_vld, n_rd_vld;
    logic [SYM_W-1:0]         r_job_bits, n_job_bits;
    logic [LEN_W-1:0]         r_job_len, n_job_len;
    logic                     r_job_ovf, n_job_ovf;
    logic                     r_found, n_found;
    logic                     r_res_valid, n_res_valid;
    logic [COUNT_OUT_W-1:0]   r_res_count, n_res_count;
    logic                     r_res_new, n_res_new;
    logic                     r_res_ovf, n_res_ovf;
    logic                     mem_rd_en;
    logic                     mem_wr_en;
    logic                     issue;
    logic                     match;
    logic [CNT_W+7:0]         cnt_ext;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_rd_vld    = r_rd_vld;
        n_job_bits  = r_job_bits;
        n_job_len   = r_job_len;
        n_job_ovf   = r_job_ovf;
        n_found     = r_found;
        n_res_valid = 1'b0;
        n_res_count = r_res_count;
        n_res_new   = r_res_new;
        n_res_ovf   = r_res_ovf;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        o_pop       = 1'b0;
        issue       = (r_addr < r_count);
        match       = r_rd_vld && (r_rd_data == {r_job_len, r_job_bits});
        cnt_ext     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop      = 1'b1;
                    n_job_bits = i_job_bits;
                    n_job_len  = i_job_len;
                    n_job_ovf  = i_job_ovf;
                    n_found    = 1'b0;
                    n_addr     = '0;
                    n_rd_vld   = 1'b0;
                    if (i_job_clr) begin
                        n_count = '0;
                    end
                    n_state = i_job_ovf ? S_RES : S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued one entry ahead of the compare.
                if (match) begin
                    n_found  = 1'b1;
                    n_rd_vld = 1'b0;
                    n_state  = S_RES;
                end else if (!issue && !r_rd_vld) begin
                    n_state = S_RES;
                end else begin
                    mem_rd_en = issue;
                    n_rd_vld  = issue;
                    if (issue) begin
                        n_addr = r_addr + CNT_W'(1);
                    end
                end
            end
            S_RES: begin
                n_res_valid = 1'b1;
                n_res_new   = 1'b0;
                n_res_ovf   = 1'b0;
                n_state     = S_IDLE;
                if (r_job_ovf) begin
                    n_res_ovf = 1'b1;
                end else if (!r_found) begin
                    if (r_count >= CNT_W'(MAX_WORDS)) begin
                        n_res_ovf = 1'b1;
                    end else begin
                        mem_wr_en = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                        n_res_new = 1'b1;
                    end
                end
                cnt_ext     = {8'd0, n_count};
                n_res_count = (cnt_ext > (CNT_W + 8)'(255)) ? 8'hFF : cnt_ext[7:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_job_len, r_job_bits};
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_job_ovf   <= 1'b0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_job_ovf   <= n_job_ovf;
            r_found     <= n_found;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_bits  <= n_job_bits;
        r_job_len   <= n_job_len;
        r_res_count <= n_res_count;
        r_res_new   <= n_res_new;
        r_res_ovf   <= n_res_ovf;
    end

    assign o_result_valid = r_res_valid;
    assign o_unique_count = r_res_count;
    assign o_was_new      = r_res_new;
    assign o_overflow     = r_res_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WORDS))
        else $error("stored pattern count exceeds table size");

    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_count))
        else $error("search address ran past the stored entries");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("two results in consecutive cycles");

    a_new_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res_new && r_res_ovf))
        else $error("result marked both new and overflow");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_valid && r_state == S_IDLE))
        else $error("word taken from queue outside idle state");

endmodule

`default_nettype wire

// File: rtl/morse_word_distinct_counter_top.sv
// ----------------------------------------------------------------------------
// morse_word_distinct_counter_top
// Counts the distinct Morse transformations of words given letter by letter.
//
//   Channel   Ports                                       Handshake
//   letters   i_letter, i_end_of_word, i_new_set          start / busy
//   results   o_unique_count, o_was_new, o_overflow       o_result_valid
//
// A letter is taken whenever busy is low; busy rises only when two finished
// words wait in the queue. The search of a word reads the patterns stored in
// the current set, one table read per cycle from the single-port pattern
// memory. Reset is synchronous and clears the word in progress, the queue and
// the count; the pattern memory is not cleared. Results cannot be stalled and
// appear for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morse_word_distinct_counter_top #(
    parameter int MAX_WORDS   = mwdc_pkg::MAX_WORDS_DEF,
    parameter int MAX_SYMBOLS = mwdc_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [mwdc_pkg::LETTER_W-1:0]    i_letter,
    input  wire logic                             i_end_of_word,
    input  wire logic                             i_new_set,
    output logic                                  o_result_valid,
    output logic [mwdc_pkg::COUNT_OUT_W-1:0]      o_unique_count,
    output logic                                  o_was_new,
    output logic                                  o_overflow
);
    import mwdc_pkg::*;

    localparam int SYM_W  = MAX_SYMBOLS;
    localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int JOB_W  = SYM_W + LEN_W + 2;

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic [JOB_W-1:0] q_in;
    logic [JOB_W-1:0] q_out;
    logic [SYM_W-1:0] f_bits;
    logic [LEN_W-1:0] f_len;
    logic             f_ovf;
    logic             f_clr;

    assign busy = q_full;
    assign q_in = {f_clr, f_ovf, f_len, f_bits};

    mwdc_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .SYM_W       (SYM_W),
        .LEN_W       (LEN_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_full        (q_full),
        .i_letter      (i_letter),
        .i_end_of_word (i_end_of_word),
        .i_new_set     (i_new_set),
        .o_push        (push),
        .o_job_bits    (f_bits),
        .o_job_len     (f_len),
        .o_job_ovf     (f_ovf),
        .o_job_clr     (f_clr)
    );

    mwdc_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    mwdc_back #(
        .MAX_WORDS   (MAX_WORDS),
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .SYM_W       (SYM_W),
        .LEN_W       (LEN_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_job_bits     (q_out[SYM_W-1:0]),
        .i_job_len      (q_out[SYM_W+LEN_W-1:SYM_W]),
        .i_job_ovf      (q_out[SYM_W+LEN_W]),
        .i_job_clr      (q_out[SYM_W+LEN_W+1]),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_unique_count (o_unique_count),
        .o_was_new      (o_was_new),
        .o_overflow     (o_overflow)
    );

endmodule

`default_nettype wire
